>>> rtl/core/c1ks_pkg.sv
// ----------------------------------------------------------------------------
// c1ks_pkg
// Shared types, operation codes and filter functions of the 48-bit
// keystream register block.
// ----------------------------------------------------------------------------
package c1ks_pkg;

   localparam int StateWidth = 48;
   localparam int KsWidth    = 8;
   localparam int RinWidth   = 32;
   localparam int CntWidth   = 5;

   // operation codes; 6 and 7 leave the register alone
   localparam logic [2:0] OP_LOAD       = 3'd0;
   localparam logic [2:0] OP_FWD_NIBBLE = 3'd1;
   localparam logic [2:0] OP_FWD_BYTE   = 3'd2;
   localparam logic [2:0] OP_BACK_BIT   = 3'd3;
   localparam logic [2:0] OP_BACK_BYTE  = 3'd4;
   localparam logic [2:0] OP_BACK_WORD  = 3'd5;

   // filter tables
   localparam logic [15:0] FiltA = 16'h9E98;
   localparam logic [15:0] FiltB = 16'hB48E;
   localparam logic [31:0] FiltC = 32'hEC57E80A;

   typedef struct packed {
      logic [2:0]            operation;
      logic [StateWidth-1:0] load_value;
      logic [RinWidth-1:0]   rollback_input;
      logic                  use_feedback;
   } c1ks_req_type;

   typedef struct packed {
      logic [KsWidth-1:0]    keystream;
      logic [StateWidth-1:0] state_out;
   } c1ks_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_DONE
   } c1ks_state_type;

   // controller -> datapath
   typedef struct packed {
      logic                capture;
      logic                step;
      logic [CntWidth-1:0] step_idx;
   } c1ks_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic last_step;
   } c1ks_status_type;

   function automatic logic has_steps(logic [2:0] op);
      return (op == OP_FWD_NIBBLE) || (op == OP_FWD_BYTE) || (op == OP_BACK_BIT) ||
             (op == OP_BACK_BYTE) || (op == OP_BACK_WORD);
   endfunction

   // four taps two apart, first tap in bit 0
   function automatic logic [3:0] nib4(logic [StateWidth-1:0] x, int p);
      return {x[p+6], x[p+4], x[p+2], x[p]};
   endfunction

   // nonlinear filter over odd taps 9..47
   function automatic logic filt(logic [StateWidth-1:0] x);
      logic [4:0] sel;
      sel[0] = FiltB[nib4(x, 9)];
      sel[1] = FiltA[nib4(x, 17)];
      sel[2] = FiltA[nib4(x, 25)];
      sel[3] = FiltB[nib4(x, 33)];
      sel[4] = FiltA[nib4(x, 41)];
      return FiltC[sel];
   endfunction

   // linear taps 5..43
   function automatic logic taps_xor(logic [StateWidth-1:0] v);
      return v[5] ^ v[9] ^ v[10] ^ v[12] ^ v[14] ^ v[15] ^ v[17] ^ v[19] ^ v[24] ^
             v[25] ^ v[27] ^ v[29] ^ v[35] ^ v[39] ^ v[41] ^ v[42] ^ v[43];
   endfunction

endpackage

>>> rtl/core/c1ks_datapath.sv
// ----------------------------------------------------------------------------
// c1ks_datapath
// Register state, latched operands and a one-step-per-cycle forward /
// rollback unit.
// ----------------------------------------------------------------------------
module c1ks_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  c1ks_pkg::c1ks_req_type   req_item,
   input  c1ks_pkg::c1ks_cmd_type   cmd,
   output c1ks_pkg::c1ks_status_type status,
   output c1ks_pkg::c1ks_rsp_type   rsp_item
);

   logic [c1ks_pkg::StateWidth-1:0] lfsr_ff;
   logic [c1ks_pkg::StateWidth-1:0] lfsr_in;
   logic [c1ks_pkg::KsWidth-1:0]    ks_ff;
   logic [c1ks_pkg::KsWidth-1:0]    ks_in;
   logic [2:0]                      op_ff;
   logic [c1ks_pkg::RinWidth-1:0]   rin_ff;
   logic                            fb_ff;

   logic [c1ks_pkg::StateWidth-1:0] shl;
   logic [c1ks_pkg::CntWidth-1:0]   bit_sel;
   logic                            in_bit;
   logic                            fwd_nb;
   logic                            back_nb;

   // backward step sees the register shifted left by one
   assign shl     = {lfsr_ff[c1ks_pkg::StateWidth-2:0], 1'b0};
   // bytes low first, bits of a byte MSB first
   assign bit_sel = {cmd.step_idx[4:3], ~cmd.step_idx[2:0]};
   assign in_bit  = (op_ff == c1ks_pkg::OP_BACK_BIT) ? rin_ff[0] : rin_ff[bit_sel];
   assign fwd_nb  = lfsr_ff[0] ^ c1ks_pkg::taps_xor(lfsr_ff);
   assign back_nb = lfsr_ff[c1ks_pkg::StateWidth-1] ^ c1ks_pkg::taps_xor(shl) ^ in_bit ^
                    (fb_ff & c1ks_pkg::filt(shl));

   always_comb begin
      lfsr_in = lfsr_ff;
      ks_in   = ks_ff;
      if (cmd.capture) begin
         ks_in = '0;
         if (req_item.operation == c1ks_pkg::OP_LOAD) begin
            lfsr_in = req_item.load_value;
         end
      end else if (cmd.step) begin
         unique case (op_ff)
            c1ks_pkg::OP_FWD_NIBBLE, c1ks_pkg::OP_FWD_BYTE: begin
               ks_in[cmd.step_idx[2:0]] = c1ks_pkg::filt(lfsr_ff);
               lfsr_in = {fwd_nb, lfsr_ff[c1ks_pkg::StateWidth-1:1]};
            end
            c1ks_pkg::OP_BACK_BIT, c1ks_pkg::OP_BACK_BYTE, c1ks_pkg::OP_BACK_WORD: begin
               lfsr_in = {shl[c1ks_pkg::StateWidth-1:1], back_nb};
            end
            default: begin
               lfsr_in = lfsr_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= '0;
      end else begin
         lfsr_ff <= lfsr_in;
      end
   end

   always_ff @(posedge clock) begin
      ks_ff <= ks_in;
      if (cmd.capture) begin
         op_ff  <= req_item.operation;
         rin_ff <= req_item.rollback_input;
         fb_ff  <= req_item.use_feedback;
      end
   end

   always_comb begin
      unique case (op_ff)
         c1ks_pkg::OP_FWD_NIBBLE: status.last_step = (cmd.step_idx == 5'd3);
         c1ks_pkg::OP_FWD_BYTE:   status.last_step = (cmd.step_idx == 5'd7);
         c1ks_pkg::OP_BACK_BYTE:  status.last_step = (cmd.step_idx == 5'd7);
         c1ks_pkg::OP_BACK_WORD:  status.last_step = (cmd.step_idx == 5'd31);
         default:                 status.last_step = 1'b1;
      endcase
   end

   assign rsp_item.keystream = ks_ff;
   assign rsp_item.state_out = lfsr_ff;

endmodule

>>> rtl/core/c1ks_ctrl.sv
// ----------------------------------------------------------------------------
// c1ks_ctrl
// Sequencer: takes a transaction, counts register steps, shows the result.
// ----------------------------------------------------------------------------
module c1ks_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [2:0]                req_op,
   input  c1ks_pkg::c1ks_status_type status,
   output c1ks_pkg::c1ks_cmd_type    cmd,
   output logic                      busy,
   output logic                      rsp_valid
);

   c1ks_pkg::c1ks_state_type      state_ff;
   c1ks_pkg::c1ks_state_type      state_in;
   logic [c1ks_pkg::CntWidth-1:0] cnt_ff;
   logic [c1ks_pkg::CntWidth-1:0] cnt_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         c1ks_pkg::ST_IDLE, c1ks_pkg::ST_DONE: begin
            if (start) begin
               state_in = c1ks_pkg::has_steps(req_op) ? c1ks_pkg::ST_STEP
                                                      : c1ks_pkg::ST_DONE;
            end else begin
               state_in = c1ks_pkg::ST_IDLE;
            end
         end
         c1ks_pkg::ST_STEP: begin
            if (status.last_step) begin
               state_in = c1ks_pkg::ST_DONE;
            end
         end
         default: state_in = c1ks_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd.capture  = start && (state_ff != c1ks_pkg::ST_STEP);
      cmd.step     = (state_ff == c1ks_pkg::ST_STEP);
      cmd.step_idx = cnt_ff;
      busy         = (state_ff == c1ks_pkg::ST_STEP);
      rsp_valid    = (state_ff == c1ks_pkg::ST_DONE);
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.capture) begin
         cnt_in = '0;
      end else if (cmd.step) begin
         cnt_in = c1ks_pkg::CntWidth'(cnt_ff + 5'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= c1ks_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   a_accept_advances: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid)
      else $error("accepted transaction did not advance the sequencer");

   a_last_step_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == c1ks_pkg::ST_STEP && status.last_step |=> rsp_valid)
      else $error("no result after last step");

   a_busy_from_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("sequencer went busy without a transaction");

   a_step_count_fresh: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> cnt_ff == '0)
      else $error("step count not cleared at start");

endmodule

>>> rtl/core/crypto1_keystream_lfsr.sv
// ----------------------------------------------------------------------------
// crypto1_keystream_lfsr
// 48-bit stream cipher register with forward keystream and rollback steps.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. The register
// moves one step per clock while busy is high, and load and the unused
// codes take no step. The result stands on rsp_item for exactly one cycle
// with rsp_valid high; the receiver cannot stall it and must take it then.
// busy is low in that cycle, so the next transaction may be started while
// the result is shown. Results keep the order of the transactions, one each.
// ----------------------------------------------------------------------------
module crypto1_keystream_lfsr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  c1ks_pkg::c1ks_req_type req_item,
   output logic                   rsp_valid,
   output c1ks_pkg::c1ks_rsp_type rsp_item
);

   c1ks_pkg::c1ks_cmd_type    cmd;
   c1ks_pkg::c1ks_status_type status;

   // sequencer: state machine and step counter
   c1ks_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_op    (req_item.operation),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // register, operand latches and the single-step unit
   c1ks_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .status   (status),
      .rsp_item (rsp_item)
   );

endmodule
